FILE: hw/rtl/lbe_pkg.sv
package lbe_pkg;

  typedef enum logic [2:0] {
    MODE_RZ      = 3'd0,
    MODE_POLAR   = 3'd1,
    MODE_BIPOLAR = 3'd2,
    MODE_AMI     = 3'd3,
    MODE_CMI     = 3'd4,
    MODE_MANCH   = 3'd5,
    MODE_HDB3    = 3'd6
  } mode_t;

  localparam logic [2:0] REG_CODE_MODE = 3'd0;
  localparam logic [2:0] REG_DIFF_EN   = 3'd1;
  localparam logic [2:0] REG_AMPLITUDE = 3'd2;
  localparam logic [2:0] REG_SPS       = 3'd3;
  localparam logic [2:0] REG_RZ_ZEROS  = 3'd4;

  localparam int HDB3_DELAY = 3;

  typedef logic signed [1:0] lvl_t;
  localparam lvl_t LVL_POS  = 2'sb01;
  localparam lvl_t LVL_NEG  = 2'sb11;
  localparam lvl_t LVL_ZERO = 2'sb00;

  typedef logic signed [3:0] dc_t;

  typedef struct packed {
    mode_t       code_mode;
    logic        diff_en;
    logic [14:0] amplitude;
    logic [6:0]  sps;
    logic [6:0]  rz_zeros;
  } cfg_t;

  // level before the split point, level after it
  typedef struct packed {
    lvl_t a;
    lvl_t b;
  } sym_lvl_t;

  function automatic lvl_t lvl_neg(input lvl_t l);
    lvl_t r;
    r = -l;
    return r;
  endfunction

endpackage

FILE: hw/rtl/lbe_cfg.sv
module lbe_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [14:0]          cfg_data,
  output lbe_pkg::cfg_t        cfg
);

  lbe_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_mode <= lbe_pkg::MODE_RZ;
      cfg_r.diff_en   <= 1'b0;
      cfg_r.amplitude <= 15'd1;
      cfg_r.sps       <= 7'd8;
      cfg_r.rz_zeros  <= 7'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lbe_pkg::REG_CODE_MODE: cfg_r.code_mode <= lbe_pkg::mode_t'(cfg_data[2:0]);
        lbe_pkg::REG_DIFF_EN:   cfg_r.diff_en   <= cfg_data[0];
        lbe_pkg::REG_AMPLITUDE: cfg_r.amplitude <= cfg_data;
        lbe_pkg::REG_SPS:       cfg_r.sps       <= cfg_data[6:0];
        lbe_pkg::REG_RZ_ZEROS:  cfg_r.rz_zeros  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lbe_enc.sv
module lbe_enc #(
  parameter  int MAX_SPS = 64,
  localparam int LEN_W   = $clog2(MAX_SPS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbe_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  logic                 data_bit,
  output lbe_pkg::sym_lvl_t    sym,
  output logic [LEN_W-1:0]     len,
  output logic [LEN_W-1:0]     split
);

  logic              pol_r, pol_nxt;
  logic              prev_r, prev_nxt;
  logic [1:0]        zr_r, zr_nxt;
  lbe_pkg::dc_t      dc_r, dc_nxt;
  lbe_pkg::lvl_t     dly_r   [lbe_pkg::HDB3_DELAY];
  lbe_pkg::lvl_t     dly_nxt [lbe_pkg::HDB3_DELAY];

  logic              bit_c;
  logic [LEN_W-1:0]  half;
  logic [LEN_W-1:0]  rz;
  lbe_pkg::lvl_t     pol_lvl;
  lbe_pkg::lvl_t     cur;
  lbe_pkg::lvl_t     oldest;

  function automatic lbe_pkg::dc_t dc_add(input lbe_pkg::dc_t dc, input logic signed [2:0] d);
    logic signed [4:0] s;
    lbe_pkg::dc_t      r;
    s = 5'(dc) + 5'(d);
    if (s > 5'sd7)       r = 4'sd7;
    else if (s < -5'sd8) r = -4'sd8;
    else                 r = s[3:0];
    return r;
  endfunction

  always_comb begin
    if (cfg.sps == 7'd0)              len = LEN_W'(1);
    else if (int'(cfg.sps) > MAX_SPS) len = LEN_W'(MAX_SPS);
    else                              len = LEN_W'(cfg.sps);
    half = len >> 1;
    if (int'(cfg.rz_zeros) > int'(len)) rz = len;
    else                                rz = LEN_W'(cfg.rz_zeros);
  end

  always_comb begin
    bit_c    = data_bit;
    prev_nxt = prev_r;
    if (cfg.diff_en) begin
      bit_c    = data_bit ^ prev_r;
      prev_nxt = data_bit;
    end

    pol_nxt = pol_r;
    zr_nxt  = zr_r;
    dc_nxt  = dc_r;
    dly_nxt = dly_r;
    pol_lvl = pol_r ? lbe_pkg::LVL_POS : lbe_pkg::LVL_NEG;
    cur     = lbe_pkg::LVL_ZERO;
    oldest  = dly_r[0];
    sym.a   = lbe_pkg::LVL_ZERO;
    sym.b   = lbe_pkg::LVL_ZERO;
    split   = len;

    unique case (cfg.code_mode)
      lbe_pkg::MODE_POLAR: begin
        sym.a = bit_c ? lbe_pkg::LVL_POS : lbe_pkg::LVL_NEG;
        sym.b = sym.a;
      end
      lbe_pkg::MODE_BIPOLAR, lbe_pkg::MODE_AMI: begin
        if (bit_c) begin
          sym.a   = pol_lvl;
          pol_nxt = ~pol_r;
        end
        sym.b = sym.a;
        if (cfg.code_mode == lbe_pkg::MODE_AMI) begin
          sym.b = lbe_pkg::LVL_ZERO;
          split = len - half;
        end
      end
      lbe_pkg::MODE_CMI: begin
        if (bit_c) begin
          sym.a   = pol_lvl;
          sym.b   = pol_lvl;
          pol_nxt = ~pol_r;
        end else begin
          sym.a = lbe_pkg::LVL_NEG;
          sym.b = lbe_pkg::LVL_POS;
          split = half;
        end
      end
      lbe_pkg::MODE_MANCH: begin
        sym.a = bit_c ? lbe_pkg::LVL_NEG : lbe_pkg::LVL_POS;
        sym.b = lbe_pkg::lvl_neg(sym.a);
        split = half;
      end
      lbe_pkg::MODE_HDB3: begin
        if (bit_c) begin
          pol_nxt = ~pol_r;
          cur     = lbe_pkg::lvl_neg(pol_lvl);
          dc_nxt  = dc_add(dc_r, 3'(cur));
          zr_nxt  = 2'd0;
        end else if (zr_r == 2'd3) begin
          if (dc_r != 4'sd0) begin
            // B00V: flip, rewrite the oldest delayed symbol as B
            pol_nxt = ~pol_r;
            cur     = lbe_pkg::lvl_neg(pol_lvl);
            oldest  = cur;
            dc_nxt  = dc_add(dc_r, pol_r ? -3'sd2 : 3'sd2);
          end else begin
            cur    = pol_lvl;
            dc_nxt = dc_add(dc_r, 3'(pol_lvl));
          end
          zr_nxt = 2'd0;
        end else begin
          zr_nxt = zr_r + 2'd1;
        end
        dly_nxt[0] = dly_r[1];
        dly_nxt[1] = dly_r[2];
        dly_nxt[2] = cur;
        sym.a = oldest;
        sym.b = oldest;
      end
      default: begin
        sym.a = bit_c ? lbe_pkg::LVL_POS : lbe_pkg::LVL_ZERO;
        split = len - rz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r  <= 1'b1;
      prev_r <= 1'b0;
      zr_r   <= 2'd0;
      dc_r   <= 4'sd0;
      for (int i = 0; i < lbe_pkg::HDB3_DELAY; i++) dly_r[i] <= lbe_pkg::LVL_ZERO;
    end else if (accept) begin
      pol_r  <= pol_nxt;
      prev_r <= prev_nxt;
      zr_r   <= zr_nxt;
      dc_r   <= dc_nxt;
      dly_r  <= dly_nxt;
    end
  end

endmodule

FILE: hw/rtl/lbe_gen.sv
module lbe_gen #(
  parameter  int MAX_SPS = 64,
  localparam int LEN_W   = $clog2(MAX_SPS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lbe_pkg::sym_lvl_t    sym,
  input  logic [LEN_W-1:0]     len,
  input  logic [LEN_W-1:0]     split,
  input  logic [14:0]          amplitude,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_sample,
  output logic                 out_last
);

  lbe_pkg::sym_lvl_t lvl_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  split_r;
  logic [LEN_W-1:0]  cnt_r;
  logic              sym_valid_r;
  logic              out_valid_r;
  logic [15:0]       sample_r, sample_nxt;
  logic              last_r;

  logic              adv;
  logic              at_end;
  logic              fin;
  logic              load;
  lbe_pkg::lvl_t     lvl;

  assign adv      = !out_valid_r || out_ready;
  assign at_end   = (cnt_r == len_r - LEN_W'(1));
  assign fin      = sym_valid_r && adv && at_end;
  assign in_ready = !sym_valid_r || fin;
  assign load     = in_valid && in_ready;

  assign lvl = (cnt_r < split_r) ? lvl_r.a : lvl_r.b;

  always_comb begin
    unique case (lvl)
      lbe_pkg::LVL_POS: sample_nxt = {1'b0, amplitude};
      lbe_pkg::LVL_NEG: sample_nxt = -{1'b0, amplitude};
      default:          sample_nxt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (load) begin
      sym_valid_r <= 1'b1;
      cnt_r       <= '0;
    end else if (fin) begin
      sym_valid_r <= 1'b0;
    end else if (sym_valid_r && adv) begin
      cnt_r <= cnt_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lvl_r   <= sym;
      len_r   <= len;
      split_r <= split;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sym_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_r <= sample_nxt;
      last_r   <= at_end;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_last   = last_r;

  a_cnt_in_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    sym_valid_r |-> (cnt_r < len_r))
    else $error("sample count beyond symbol length");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sym_valid_r |-> (len_r != '0))
    else $error("symbol held with zero length");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (sym_valid_r && cnt_r == '0))
    else $error("new item did not restart the sample count");

  a_no_early_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (sym_valid_r && !fin) |=> sym_valid_r)
    else $error("symbol dropped before its last sample");

endmodule

FILE: hw/rtl/baseband_line_encoder_top.sv
// An item's first sample passes the symbol register, then the sample output register.
// One sample per cycle while out_tready is high; an item gives samples_per_symbol samples
// (clamped to 1..MAX_SAMPLES_PER_SYMBOL); the next item is taken with its last sample.
// HDB3 symbols leave three items after the bit that made them.
// Reset (rst_n low, synchronous) clears all coder state and restores register defaults.
module baseband_line_encoder_top #(
  parameter int MAX_SAMPLES_PER_SYMBOL = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] data_bit, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample (signed)
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_SAMPLES_PER_SYMBOL + 1);

  lbe_pkg::cfg_t     cfg;
  lbe_pkg::sym_lvl_t sym;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  split;
  logic              accept;

  assign accept = in_tvalid && in_tready;

  lbe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbe_enc #(.MAX_SPS(MAX_SAMPLES_PER_SYMBOL)) u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (accept),
    .data_bit (in_tdata[0]),
    .sym      (sym),
    .len      (len),
    .split    (split)
  );

  lbe_gen #(.MAX_SPS(MAX_SAMPLES_PER_SYMBOL)) u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .sym        (sym),
    .len        (len),
    .split      (split),
    .amplitude  (cfg.amplitude),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
